>>> sv/edp_pkg.sv
`default_nettype none
package edp_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    typedef enum logic [3:0] {
        PH_HDR    = 4'd0,
        PH_LEN    = 4'd1,
        PH_EVNO   = 4'd2,
        PH_TYPE   = 4'd3,
        PH_DIMX   = 4'd4,
        PH_DIMY   = 4'd5,
        PH_NAMES  = 4'd6,
        PH_PLAYER = 4'd7,
        PH_PX     = 4'd8,
        PH_PY     = 4'd9,
        PH_CRC    = 4'd10
    } t_phase;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_NAME_END = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;

    localparam logic [3:0] ST_OK = 4'd0;
    localparam logic [3:0] ST_BAD_CRC = 4'd1;
    localparam logic [3:0] ST_BAD_LEN = 4'd2;
    localparam logic [3:0] ST_BAD_TYPE = 4'd3;
    localparam logic [3:0] ST_BAD_DIM = 4'd4;
    localparam logic [3:0] ST_BAD_NAME = 4'd5;
    localparam logic [3:0] ST_BAD_PLAYER = 4'd6;
    localparam logic [3:0] ST_BAD_PIXEL = 4'd7;
    localparam logic [3:0] ST_TOO_LONG = 4'd8;

    localparam logic [1:0] REG_MAX_DGRAM = 2'd0;
    localparam logic [1:0] REG_MAX_WIDTH = 2'd1;
    localparam logic [1:0] REG_MAX_HEIGHT = 2'd2;

    localparam logic [1:0] EV_NEW_GAME = 2'd0;
    localparam logic [1:0] EV_PIXEL = 2'd1;
    localparam logic [1:0] EV_ELIM = 2'd2;
    localparam logic [1:0] EV_GAME_OVER = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_char;
        logic [31:0] game_id;
        logic [31:0] event_number;
        logic [1:0]  event_type;
        logic [11:0] coord_x;
        logic [11:0] coord_y;
        logic [7:0]  player_index;
        logic [7:0]  player_count;
        logic [3:0]  status;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic [11:0] sat12(input logic [31:0] v);
        return (v > 32'd4095) ? 12'hFFF : v[11:0];
    endfunction

endpackage
`default_nettype wire

>>> sv/event_datagram_parser_crc_check_unit.sv
`default_nettype none
// Event datagram parser with CRC check.
// Slave stream: one datagram byte per word. tdata = {datagram_length[10:0],
// data_byte[7:0]} padded to 24 bits; tuser = first_byte; tlast = last_byte.
// Master stream: zero or one result word per accepted byte, carrying name
// characters, end-of-name marks and decoded records with their status;
// tuser carries the result kind.
// Config channel: index 0 max datagram bytes, 1 max width, 2 max height;
// write only while idle.
// Throughput: one byte per cycle while the output buffer has room. Each byte is
// parsed combinationally by the byte-wide CRC step and field shifter; its result
// enters a two-entry output buffer, whose registered output drives tvalid.
// A stalled receiver fills the buffer; tready then drops until a slot frees.
// Reset (synchronous, active low) returns to the header phase with default
// limits; after a fatal error the block ignores all bytes until reset.
module event_datagram_parser_crc_check_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // data_byte[7:0], datagram_length[18:8]
    input  wire         s_axis_tuser,   // first_byte
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // name_char[7:0], game_id[39:8], event_number[71:40], event_type[73:72],
    // coord_x[85:74], coord_y[97:86], player_index[105:98],
    // player_count[113:106], status[117:114]
    output logic [119:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [11:0] i_cfg_data
);
    import edp_pkg::*;

    logic [10:0] r_max_dgram;
    logic [11:0] r_max_w, r_max_h;
    logic [10:0] r_pos, n_pos, r_dlen, n_dlen;
    t_phase      r_ph, n_ph;
    logic [11:0] r_fbc, n_fbc;
    logic [31:0] r_crc, n_crc, r_sh, n_sh;
    logic [31:0] r_len, n_len, r_evno, n_evno, r_f3, n_f3, r_f4, n_f4;
    logic [1:0]  r_typ, n_typ;
    logic [7:0]  r_f5, n_f5;
    logic [31:0] r_gid, n_gid;
    logic [11:0] r_bw, n_bw, r_bh, n_bh;
    logic [7:0]  r_ns, n_ns;
    logic        r_skip, n_skip, r_halt, n_halt;

    logic        in_acc, res_v, buf_ready;
    t_result     res;
    logic [7:0]  b;
    logic        first, last;
    logic [10:0] len;
    logic [31:0] shv, crcb;
    logic        full4;

    assign b      = s_axis_tdata[7:0];
    assign len    = s_axis_tdata[18:8];
    assign first  = s_axis_tuser;
    assign last   = s_axis_tlast;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = buf_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dgram <= 11'd550;
            r_max_w     <= 12'd3920;
            r_max_h     <= 12'd2220;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAX_DGRAM:  r_max_dgram <= i_cfg_data[10:0];
                REG_MAX_WIDTH:  r_max_w <= i_cfg_data;
                REG_MAX_HEIGHT: r_max_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [31:0] sh0;
        logic [11:0] fbc0;
        logic [31:0] ev0, l0, f30, f40;
        logic [1:0]  t0;
        logic [7:0]  p0;
        logic [31:0] gid0;
        logic        go;
        logic [11:0] tk;
        logic        emit;
        logic [1:0]  kd;
        logic [7:0]  ch;
        logic [3:0]  st;
        logic        start;

        n_pos = r_pos; n_dlen = r_dlen; n_ph = r_ph; n_fbc = r_fbc;
        n_crc = r_crc; n_sh = r_sh; n_len = r_len; n_evno = r_evno;
        n_f3 = r_f3; n_f4 = r_f4; n_typ = r_typ; n_f5 = r_f5; n_gid = r_gid;
        n_bw = r_bw; n_bh = r_bh; n_ns = r_ns; n_skip = r_skip; n_halt = r_halt;
        emit = 1'b0; kd = KIND_RECORD; ch = 8'd0; st = ST_OK; start = 1'b0;
        go = 1'b0; shv = '0; crcb = '0; full4 = 1'b0; tk = '0;

        sh0 = r_sh; fbc0 = r_fbc; ev0 = r_evno; l0 = r_len; f30 = r_f3;
        f40 = r_f4; t0 = r_typ; p0 = r_f5; gid0 = r_gid;

        if (in_acc && !r_halt) begin
            if (first) begin
                n_pos = 11'd0; n_dlen = len; n_ph = PH_HDR; fbc0 = 12'd0; sh0 = '0;
                gid0 = '0; n_skip = 1'b0;
                l0 = '0; ev0 = '0; t0 = '0; f30 = '0; f40 = '0; p0 = '0;
                n_fbc = fbc0; n_sh = sh0; n_gid = gid0; n_len = l0; n_evno = ev0;
                n_typ = t0; n_f3 = f30; n_f4 = f40; n_f5 = p0;
                if (len > r_max_dgram) begin
                    emit = 1'b1; st = ST_TOO_LONG; n_halt = 1'b1;
                end else begin
                    go = 1'b1;
                end
            end else if (!r_skip) begin
                go = 1'b1;
            end
            if (go && ((first ? 11'd0 : r_pos) >= (first ? len : r_dlen))) begin
                go = 1'b0;
                n_skip = 1'b1;
            end
        end

        if (go) begin
            t_phase ph;
            ph = first ? PH_HDR : r_ph;
            crcb = crc_byte(r_crc, b);
            if (ph != PH_HDR && ph != PH_CRC) n_crc = crcb;
            shv = {sh0[23:0], b};
            tk = fbc0 + 12'd1;
            full4 = (tk >= 12'd4);
            case (ph)
                PH_HDR, PH_LEN, PH_EVNO, PH_DIMX, PH_DIMY, PH_PX, PH_PY, PH_CRC: begin
                    n_sh = shv;
                    n_fbc = full4 ? 12'd0 : tk;
                end
                default: ;
            endcase
            case (ph)
                PH_HDR: begin
                    n_gid = {gid0[23:0], b};
                    if (full4) start = 1'b1;
                end
                PH_LEN: if (full4) begin
                    n_len = shv;
                    if ({1'b0, shv} + 33'd5 + {22'd0, r_pos} > {22'd0, n_dlen}) begin
                        emit = 1'b1; st = ST_BAD_LEN; n_halt = 1'b1;
                    end else n_ph = PH_EVNO;
                end
                PH_EVNO: if (full4) begin
                    n_evno = shv; n_ph = PH_TYPE;
                end
                PH_TYPE: begin
                    if (b > 8'd3) begin
                        emit = 1'b1; st = ST_BAD_TYPE; n_halt = 1'b1;
                    end else begin
                        n_typ = b[1:0];
                        case (b[1:0])
                            EV_NEW_GAME: begin
                                if (r_len < 32'd13) begin
                                    emit = 1'b1; st = ST_BAD_LEN; n_halt = 1'b1;
                                end else n_ph = PH_DIMX;
                            end
                            EV_GAME_OVER: n_ph = PH_CRC;
                            default: n_ph = PH_PLAYER;
                        endcase
                    end
                end
                PH_DIMX: if (full4) begin
                    n_f3 = shv; n_bw = sat12(shv);
                    if (shv > {20'd0, r_max_w}) begin
                        emit = 1'b1; st = ST_BAD_DIM; n_skip = 1'b1;
                    end else n_ph = PH_DIMY;
                end
                PH_DIMY: if (full4) begin
                    n_f4 = shv; n_bh = sat12(shv);
                    if (shv > {20'd0, r_max_h}) begin
                        emit = 1'b1; st = ST_BAD_DIM; n_skip = 1'b1;
                    end else begin
                        logic [31:0] rem;
                        rem = r_len - 32'd13;
                        n_ns = 8'd0;
                        n_fbc = rem[11:0];
                        n_ph = (rem[11:0] != 12'd0) ? PH_NAMES : PH_CRC;
                    end
                end
                PH_NAMES: begin
                    n_fbc = r_fbc - 12'd1;
                    if (n_fbc == 12'd0) n_ph = PH_CRC;
                    emit = 1'b1; st = ST_OK;
                    if (b == 8'd0) begin
                        if (r_ns != 8'd255) n_ns = r_ns + 8'd1;
                        kd = KIND_NAME_END;
                    end else if (b < 8'd33 || b > 8'd126) begin
                        st = ST_BAD_NAME; n_halt = 1'b1;
                    end else begin
                        kd = KIND_CHAR; ch = b;
                    end
                end
                PH_PLAYER: begin
                    n_f5 = b;
                    n_ph = (r_typ == EV_PIXEL) ? PH_PX : PH_CRC;
                end
                PH_PX: if (full4) begin
                    n_f3 = shv; n_ph = PH_PY;
                end
                PH_PY: if (full4) begin
                    n_f4 = shv; n_ph = PH_CRC;
                end
                default: if (full4) begin
                    emit = 1'b1;
                    if (shv != ~r_crc) begin
                        st = ST_BAD_CRC; n_skip = 1'b1;
                    end else if ((r_typ == EV_PIXEL || r_typ == EV_ELIM)
                                 && r_f5 >= r_ns) begin
                        st = ST_BAD_PLAYER; n_halt = 1'b1;
                    end else if (r_typ == EV_PIXEL
                                 && (r_f3 >= {20'd0, r_bw} || r_f4 >= {20'd0, r_bh})) begin
                        st = ST_BAD_PIXEL; n_halt = 1'b1;
                    end else begin
                        st = ST_OK; start = 1'b1;
                    end
                end
            endcase
            n_pos = (first ? 11'd0 : r_pos) + 11'd1;
            if (!n_halt && (last || n_pos >= n_dlen)) n_skip = 1'b1;
        end

        res.kind         = kd;
        res.name_char    = ch;
        res.game_id      = n_gid;
        res.event_number = n_evno;
        res.event_type   = n_typ;
        res.coord_x      = sat12(n_f3);
        res.coord_y      = sat12(n_f4);
        res.player_index = n_f5;
        res.player_count = n_ns;
        res.status       = st;
        res_v = emit;

        if (start) begin
            n_len = '0; n_evno = '0; n_typ = '0; n_f3 = '0; n_f4 = '0; n_f5 = '0;
            n_crc = 32'hFFFFFFFF; n_fbc = '0; n_sh = '0; n_ph = PH_LEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_dlen <= '0; r_ph <= PH_HDR; r_fbc <= '0;
            r_crc <= 32'hFFFFFFFF; r_sh <= '0; r_len <= '0; r_evno <= '0;
            r_f3 <= '0; r_f4 <= '0; r_typ <= '0; r_f5 <= '0; r_gid <= '0;
            r_bw <= '0; r_bh <= '0; r_ns <= '0; r_skip <= 1'b0; r_halt <= 1'b0;
        end else begin
            r_pos <= n_pos; r_dlen <= n_dlen; r_ph <= n_ph; r_fbc <= n_fbc;
            r_crc <= n_crc; r_sh <= n_sh; r_len <= n_len; r_evno <= n_evno;
            r_f3 <= n_f3; r_f4 <= n_f4; r_typ <= n_typ; r_f5 <= n_f5; r_gid <= n_gid;
            r_bw <= n_bw; r_bh <= n_bh; r_ns <= n_ns; r_skip <= n_skip;
            r_halt <= n_halt;
        end
    end

    t_result out_res;

    edp_out_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_v),
        .o_ready (buf_ready),
        .i_data  (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tdata = {2'd0, out_res.status, out_res.player_count,
                           out_res.player_index, out_res.coord_y, out_res.coord_x,
                           out_res.event_type, out_res.event_number, out_res.game_id,
                           out_res.name_char};
    assign m_axis_tuser = out_res.kind;

`ifndef SYNTH
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt cleared without reset");
    a_no_emit_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> !res_v) else $error("result while halted");
    a_crc_preset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_LEN && r_fbc == 12'd0 && $past(r_ph) == PH_HDR)
        |-> r_crc == 32'hFFFFFFFF)
        else $error("crc not preset at record start");
`endif
endmodule
`default_nettype wire

>>> sv/edp_out_buf.sv
`default_nettype none
module edp_out_buf (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire edp_pkg::t_result  i_data,
    output logic                   o_valid,
    input  wire                    i_ready,
    output edp_pkg::t_result       o_data
);
    import edp_pkg::*;

    logic    r_full, r_skid_full;
    t_result r_skid;

    assign o_ready = !r_skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full      <= 1'b0;
            r_skid_full <= 1'b0;
        end else begin
            if (!r_full || i_ready) begin
                if (r_skid_full) begin
                    o_data      <= r_skid;
                    r_full      <= 1'b1;
                    r_skid_full <= 1'b0;
                end else begin
                    r_full <= i_valid;
                    if (i_valid) o_data <= i_data;
                end
            end else if (i_valid && !r_skid_full) begin
                r_skid      <= i_data;
                r_skid_full <= 1'b1;
            end
        end
    end

    assign o_valid = r_full;
endmodule
`default_nettype wire

>>> tb/sv/tb_event_datagram_parser_crc_check_unit.sv
`default_nettype none
module tb_event_datagram_parser_crc_check_unit;
    import edp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 600000;

    typedef struct {
        logic [7:0]  b;
        bit          first;
        logic [10:0] len;
        bit          last;
    } t_byte_word;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [23:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         s_axis_tlast = 1'b0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    wire  [119:0] m_axis_tdata;
    wire  [1:0]   m_axis_tuser;
    logic         i_cfg_valid = 1'b0;
    wire          o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [11:0]  i_cfg_data = '0;

    event_datagram_parser_crc_check_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // parser mirror
    logic [10:0]  cfg_maxd;
    logic [11:0]  cfg_maxw, cfg_maxh;
    logic [10:0]  pos, dlen;
    t_phase       ph;
    logic [11:0]  fcnt;
    logic [31:0]  crc, shf, gid;
    logic [31:0]  rf [6];
    logic [11:0]  bw, bh;
    logic [7:0]   nseen;
    bit           skip, halt;

    logic [119:0] record_q [$];
    t_byte_word   byte_q [$];
    t_byte_word   cur;
    int           gap = 0, stall = 0, errors = 0, cyc = 0, sent = 0;
    bit           calm = 0;

    // stimulus tracking of the game as the block will see it
    logic [7:0]   dg_buf [$];
    logic [7:0]   body [$];
    int unsigned  g_w, g_h, g_n;
    bit           g_ok, open_dg;

    int    fld_lo [10] = '{0, 2, 10, 42, 74, 76, 88, 100, 108, 116};
    int    fld_w  [10] = '{2, 8, 32, 32, 2, 12, 12, 8, 8, 4};
    string fld_nm [10] = '{"kind", "name_char", "game_id", "event_number", "event_type",
                           "coord_x", "coord_y", "player_index", "player_count", "status"};

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        c = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return c;
    endfunction

    function automatic logic [11:0] clip12(logic [31:0] v);
        return (v > 32'd4095) ? 12'hFFF : v[11:0];
    endfunction

    function automatic void emit(logic [1:0] k, logic [7:0] ch, logic [3:0] st);
        record_q.insert(record_q.size(),
                        {st, nseen, rf[5][7:0], clip12(rf[4]), clip12(rf[3]),
                         rf[2][1:0], rf[1], gid, ch, k});
    endfunction

    function automatic void fail_rec(logic [3:0] st, bit stop);
        emit(KIND_RECORD, 8'd0, st);
        if (stop)
            halt = 1;
        else
            skip = 1;
    endfunction

    function automatic bit take(logic [7:0] b);
        shf = {shf[23:0], b};
        fcnt++;
        if (fcnt >= 12'd4) begin
            fcnt = 0;
            return 1;
        end
        return 0;
    endfunction

    function automatic void start_rec();
        for (int i = 0; i < 6; i++)
            rf[i] = 0;
        crc = 32'hFFFFFFFF;
        fcnt = 0;
        shf = 0;
        ph = PH_LEN;
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        if (ph != PH_HDR && ph != PH_CRC)
            crc = crc_step(crc, b);
        case (ph)
            PH_HDR: begin
                gid = {gid[23:0], b};
                if (take(b))
                    start_rec();
            end
            PH_LEN: begin
                if (take(b)) begin
                    rf[0] = shf;
                    if (64'(rf[0]) + 64'(pos) + 64'd5 > 64'(dlen))
                        fail_rec(ST_BAD_LEN, 1);
                    else
                        ph = PH_EVNO;
                end
            end
            PH_EVNO: begin
                if (take(b)) begin
                    rf[1] = shf;
                    ph = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (b > 8'd3) begin
                    fail_rec(ST_BAD_TYPE, 1);
                end else begin
                    rf[2] = {24'd0, b};
                    if (b[1:0] == EV_NEW_GAME) begin
                        if (rf[0] < 32'd13)
                            fail_rec(ST_BAD_LEN, 1);
                        else
                            ph = PH_DIMX;
                    end else if (b[1:0] == EV_GAME_OVER) begin
                        ph = PH_CRC;
                    end else begin
                        ph = PH_PLAYER;
                    end
                end
            end
            PH_DIMX: begin
                if (take(b)) begin
                    rf[3] = shf;
                    bw = clip12(shf);
                    if (shf > 32'(cfg_maxw))
                        fail_rec(ST_BAD_DIM, 0);
                    else
                        ph = PH_DIMY;
                end
            end
            PH_DIMY: begin
                if (take(b)) begin
                    rf[4] = shf;
                    bh = clip12(shf);
                    if (shf > 32'(cfg_maxh)) begin
                        fail_rec(ST_BAD_DIM, 0);
                    end else begin
                        nseen = 0;
                        fcnt = 12'(rf[0] - 32'd13);
                        ph = (fcnt != 0) ? PH_NAMES : PH_CRC;
                    end
                end
            end
            PH_NAMES: begin
                fcnt--;
                if (fcnt == 0)
                    ph = PH_CRC;
                if (b == 8'd0) begin
                    if (nseen < 8'd255)
                        nseen++;
                    emit(KIND_NAME_END, 8'd0, ST_OK);
                end else if (b < 8'd33 || b > 8'd126) begin
                    fail_rec(ST_BAD_NAME, 1);
                end else begin
                    emit(KIND_CHAR, b, ST_OK);
                end
            end
            PH_PLAYER: begin
                rf[5] = {24'd0, b};
                ph = (rf[2][1:0] == EV_PIXEL) ? PH_PX : PH_CRC;
            end
            PH_PX: begin
                if (take(b)) begin
                    rf[3] = shf;
                    ph = PH_PY;
                end
            end
            PH_PY: begin
                if (take(b)) begin
                    rf[4] = shf;
                    ph = PH_CRC;
                end
            end
            default: begin
                if (take(b)) begin
                    if (shf != ~crc)
                        fail_rec(ST_BAD_CRC, 0);
                    else if ((rf[2][1:0] == EV_PIXEL || rf[2][1:0] == EV_ELIM)
                             && rf[5] >= 32'(nseen))
                        fail_rec(ST_BAD_PLAYER, 1);
                    else if (rf[2][1:0] == EV_PIXEL
                             && (rf[3] >= 32'(bw) || rf[4] >= 32'(bh)))
                        fail_rec(ST_BAD_PIXEL, 1);
                    else begin
                        emit(KIND_RECORD, 8'd0, ST_OK);
                        start_rec();
                    end
                end
            end
        endcase
    endfunction

    function automatic void predict_word(t_byte_word w);
        if (halt)
            return;
        if (w.first) begin
            pos = 0;
            dlen = w.len;
            ph = PH_HDR;
            fcnt = 0;
            shf = 0;
            gid = 0;
            skip = 0;
            for (int i = 0; i < 6; i++)
                rf[i] = 0;
            if (w.len > cfg_maxd) begin
                fail_rec(ST_TOO_LONG, 1);
                return;
            end
        end else if (skip) begin
            return;
        end
        if (pos >= dlen) begin
            skip = 1;
            return;
        end
        parse_byte(w.b);
        pos = pos + 11'd1;
        if (!halt && (w.last || pos >= dlen))
            skip = 1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_word(cur);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap > 0) begin
                    gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    cur = byte_q.pop_front();
                    s_axis_tdata <= {5'd0, cur.len, cur.b};
                    s_axis_tuser <= cur.first;
                    s_axis_tlast <= cur.last;
                    s_axis_tvalid <= 1'b1;
                    gap = calm ? 0 : $urandom_range(0, 11);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        logic [119:0] want, msk, got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[117:0], m_axis_tuser};
                if (record_q.size() == 0) begin
                    $display("%0t unexpected word: expected none, actual %h",
                             $time, got);
                    errors++;
                end else begin
                    want = record_q.pop_front();
                    for (int i = 0; i < 10; i++) begin
                        msk = (120'd1 << fld_w[i]) - 120'd1;
                        if (((want >> fld_lo[i]) & msk) != ((got >> fld_lo[i]) & msk)) begin
                            $display("%0t %s: expected %0h, actual %0h", $time, fld_nm[i],
                                     (want >> fld_lo[i]) & msk,
                                     (got >> fld_lo[i]) & msk);
                            errors++;
                        end
                    end
                end
                stall = calm ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic void push_word(logic [7:0] b, bit first, logic [10:0] len, bit last);
        t_byte_word w;
        w.b = b;
        w.first = first;
        w.len = len;
        w.last = last;
        byte_q.insert(byte_q.size(), w);
        sent++;
    endfunction

    function automatic void put32(logic [31:0] v);
        for (int i = 3; i >= 0; i--)
            body.insert(body.size(), v[8*i +: 8]);
    endfunction

    function automatic void close_rec(bit bad, bit force_len, logic [31:0] lenv);
        logic [31:0] len, c;
        logic [7:0]  rec [$];
        len = force_len ? lenv : 32'(body.size());
        for (int i = 3; i >= 0; i--)
            rec.insert(rec.size(), len[8*i +: 8]);
        foreach (body[i])
            rec.insert(rec.size(), body[i]);
        c = 32'hFFFFFFFF;
        foreach (rec[i])
            c = crc_step(c, rec[i]);
        c = ~c;
        if (bad)
            c = c ^ ($urandom | 32'd1);
        foreach (rec[i])
            dg_buf.insert(dg_buf.size(), rec[i]);
        for (int i = 3; i >= 0; i--)
            dg_buf.insert(dg_buf.size(), c[8*i +: 8]);
        body.delete();
    endfunction

    function automatic bit rec_new(logic [31:0] w, logic [31:0] h, int nn,
                                   logic [7:0] badc, bit bad);
        int cnt;
        put32($urandom);
        body.insert(body.size(), {6'd0, EV_NEW_GAME});
        put32(w);
        put32(h);
        if (badc != 0)
            body.insert(body.size(), badc);
        for (int i = 0; i < nn; i++) begin
            cnt = $urandom_range(1, 5);
            repeat (cnt) body.insert(body.size(), 8'($urandom_range(33, 126)));
            body.insert(body.size(), 8'd0);
        end
        close_rec(bad, 0, 0);
        if (w > 32'(cfg_maxw)) begin
            g_w = clip12(w);
            g_ok = 0;
            return 0;
        end
        g_w = w;
        if (h > 32'(cfg_maxh)) begin
            g_h = clip12(h);
            g_ok = 0;
            return 0;
        end
        g_h = h;
        g_n = nn;
        g_ok = 1;
        return !bad;
    endfunction

    function automatic bit rec_pix(logic [7:0] p, logic [31:0] x, logic [31:0] y, bit bad);
        put32($urandom);
        body.insert(body.size(), {6'd0, EV_PIXEL});
        body.insert(body.size(), p);
        put32(x);
        put32(y);
        close_rec(bad, 0, 0);
        return !bad;
    endfunction

    function automatic bit rec_elim(logic [7:0] p, bit bad);
        put32($urandom);
        body.insert(body.size(), {6'd0, EV_ELIM});
        body.insert(body.size(), p);
        close_rec(bad, 0, 0);
        return !bad;
    endfunction

    function automatic bit rec_over(bit bad);
        put32($urandom);
        body.insert(body.size(), {6'd0, EV_GAME_OVER});
        close_rec(bad, 0, 0);
        return !bad;
    endfunction

    function automatic bit gen_record();
        int r;
        bit bad;
        logic [31:0] w, h;
        r = $urandom_range(0, 99);
        bad = ($urandom_range(0, 99) < 7);
        if (r < 30) begin
            w = $urandom_range(0, cfg_maxw);
            h = $urandom_range(0, cfg_maxh);
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    w = 32'(cfg_maxw) + 32'($urandom_range(1, 3));
                else
                    h = $urandom | 32'h0000_1000;
            end
            return rec_new(w, h, $urandom_range(0, 3), 8'd0, bad);
        end else if (r < 60 && g_ok && g_n > 0 && g_w > 0 && g_h > 0) begin
            return rec_pix(8'($urandom_range(0, g_n - 1)), $urandom_range(0, g_w - 1),
                           $urandom_range(0, g_h - 1), bad);
        end else if (r < 80 && g_ok && g_n > 0) begin
            return rec_elim(8'($urandom_range(0, g_n - 1)), bad);
        end
        return rec_over(bad);
    endfunction

    // mode: 0 exact length, 1 stated length at or beyond the end, 2 cut with last, 3 cut open
    function automatic void send_dgram(logic [31:0] id, int mode);
        logic [7:0]  full [$];
        logic [10:0] len;
        int n;
        for (int i = 3; i >= 0; i--)
            full.insert(full.size(), id[8*i +: 8]);
        foreach (dg_buf[i])
            full.insert(full.size(), dg_buf[i]);
        n = (mode >= 2) ? $urandom_range(1, full.size() - 1) : full.size();
        len = (mode == 1) ? 11'($urandom_range(full.size(), cfg_maxd)) : 11'(full.size());
        for (int i = 0; i < n; i++)
            push_word(full[i], i == 0, (i == 0) ? len : 11'($urandom),
                      (i == n - 1) && mode != 3);
        if (mode >= 2)
            g_ok = 0;
        open_dg = (mode == 3);
        dg_buf.delete();
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_MAX_DGRAM: cfg_maxd = val[10:0];
            REG_MAX_WIDTH: cfg_maxw = val;
            default:       cfg_maxh = val;
        endcase
    endtask

    task automatic set_limits(logic [10:0] d, logic [11:0] w, logic [11:0] h);
        write_reg(REG_MAX_DGRAM, {1'b0, d});
        write_reg(REG_MAX_WIDTH, w);
        write_reg(REG_MAX_HEIGHT, h);
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || s_axis_tvalid || record_q.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    function automatic logic [11:0] pick_dim();
        case ($urandom_range(0, 4))
            0: return 12'hFFF;
            1: return 12'd0;
            2: return 12'd1;
            default: return 12'($urandom);
        endcase
    endfunction

    initial begin
        int target, n, f;
        bit go;
        cfg_maxd = 11'd550;
        cfg_maxw = 12'd3920;
        cfg_maxh = 12'd2220;
        pos = 0; dlen = 0; ph = PH_HDR; fcnt = 0; crc = 32'hFFFFFFFF; shf = 0; gid = 0;
        for (int i = 0; i < 6; i++)
            rf[i] = 0;
        bw = 0; bh = 0; nseen = 0; skip = 0; halt = 0;
        g_w = 0; g_h = 0; g_n = 0; g_ok = 0; open_dg = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        go = rec_new(32'd3920, 32'd2220, 2, 8'd0, 0);
        go = rec_pix(8'd1, 32'd3919, 32'd2219, 0);
        go = rec_elim(8'd0, 0);
        go = rec_over(1);
        send_dgram(32'hFFFFFFFF, 0);
        go = rec_new(32'd3921, 32'd5, 1, 8'd0, 0);
        send_dgram(32'h0, 1);
        go = rec_new(32'd10, 32'd2221, 0, 8'd0, 0);
        send_dgram($urandom, 0);
        go = rec_new(32'd100, 32'd100, 2, 8'd0, 0);
        go = rec_over(0);
        send_dgram($urandom, 2);
        settle();

        set_limits(11'd0, 12'd0, 12'd0);
        push_word(8'($urandom), 1, 11'd0, 1);
        push_word(8'($urandom), 0, 11'($urandom), 0);
        settle();

        set_limits(11'd2047, 12'hFFF, 12'hFFF);
        go = rec_new(32'hFFFFFFFF, 32'd0, 0, 8'd0, 0);
        send_dgram($urandom, 0);
        go = rec_new(32'd4095, 32'd4095, 0, 8'd0, 0);
        go = rec_over(0);
        send_dgram($urandom, 1);
        settle();

        for (int p = 0; p < 5; p++) begin
            set_limits(11'($urandom_range(200, 2046)), pick_dim(), pick_dim());
            calm = (p == 2);
            target = sent + 100;
            while (sent < target) begin
                n = $urandom_range(1, 4);
                go = 1;
                for (int k = 0; k < n && go; k++)
                    go = gen_record();
                f = $urandom_range(0, 19);
                send_dgram($urandom, (f < 2) ? 2 : (f == 2) ? 3 : (f < 7) ? 1 : 0);
                if (!open_dg && $urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 3))
                        push_word(8'($urandom), 0, 11'($urandom),
                                  1'($urandom_range(0, 1)));
            end
            settle();
        end

        calm = 0;
        f = $urandom_range(0, 6);
        case (f)
            0: push_word(8'($urandom), 1, cfg_maxd + 11'd1, 0);
            1: begin
                put32($urandom);
                close_rec(0, 1, 32'hFFFF0000 | $urandom);
            end
            2: begin
                put32($urandom);
                body.insert(body.size(), 8'($urandom_range(4, 255)));
                close_rec(0, 0, 0);
            end
            3: go = rec_new(32'd0, 32'd0, 1, ($urandom_range(0, 1) == 0) ?
                            8'($urandom_range(1, 32)) : 8'($urandom_range(127, 255)), 0);
            4: begin
                go = rec_new(32'd0, 32'd0, 1, 8'd0, 0);
                go = rec_elim(8'($urandom_range(1, 255)), 0);
            end
            5: begin
                go = rec_new(32'd0, 32'd0, 1, 8'd0, 0);
                go = rec_pix(8'd0, $urandom_range(0, 50), $urandom_range(0, 50), 0);
            end
            default: begin
                put32($urandom);
                body.insert(body.size(), {6'd0, EV_NEW_GAME});
                put32(32'd0);
                put32(32'd0);
                close_rec(0, 1, $urandom_range(0, 12));
            end
        endcase
        if (f != 0)
            send_dgram($urandom, 0);
        repeat (5) push_word(8'($urandom), 1'($urandom_range(0, 1)), 11'($urandom), 0);
        settle();
        repeat (20) @(negedge i_clk);

        if (errors == 0 && record_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
`default_nettype wire
